// ===== sv/tlbpt_pkg.sv =====
// Shared types, constants and state codes for the TLB page table translator.
`timescale 1ns / 1ps

package tlbpt_pkg;

   localparam int VA_W            = 16;
   localparam int PAGE_TAG_W      = 8;
   localparam int OFFSET_W        = 8;
   localparam int FRAME_W         = 8;
   localparam int FREE_CNT_W      = 9;
   localparam int DEF_TLB_ENTRIES = 16;
   localparam int DEF_PAGE_COUNT  = 256;

   // free frame counter saturates here
   localparam logic [FREE_CNT_W-1:0] FRAME_LIMIT = FREE_CNT_W'(256);

   // priority match word handed from cell to cell
   typedef struct packed {
      logic               hit;
      logic [FRAME_W-1:0] frame;
   } tlbpt_match_type;

   // page table controls from the sequencer
   typedef struct packed {
      logic rd_en;
      logic alloc_en;
   } tlbpt_pt_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_FIN
   } tlbpt_state_type;

endpackage

// ===== sv/tlbpt_cell.sv =====
// One TLB entry: holds tag, frame and valid bit and extends the priority match chain.
`timescale 1ns / 1ps

module tlbpt_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_en,
   input  logic [tlbpt_pkg::PAGE_TAG_W-1:0]    wr_tag,
   input  logic [tlbpt_pkg::FRAME_W-1:0]       wr_frame,
   input  logic [tlbpt_pkg::PAGE_TAG_W-1:0]    look_page,
   input  tlbpt_pkg::tlbpt_match_type          chain_in,
   output tlbpt_pkg::tlbpt_match_type          chain_out
);
   import tlbpt_pkg::*;

   logic                  valid_ff;
   logic [PAGE_TAG_W-1:0] tag_ff;
   logic [FRAME_W-1:0]    frame_ff;

   // entry valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wr_en) begin
         valid_ff <= 1'b1;
      end
   end

   // entry payload
   always_ff @(posedge clock) begin
      if (wr_en) begin
         tag_ff   <= wr_tag;
         frame_ff <= wr_frame;
      end
   end

   // an earlier (lower) cell's match wins
   always_comb begin
      if (chain_in.hit) begin
         chain_out = chain_in;
      end else if (valid_ff && (tag_ff == look_page)) begin
         chain_out.hit   = 1'b1;
         chain_out.frame = frame_ff;
      end else begin
         chain_out = chain_in;
      end
   end

endmodule

// ===== sv/tlbpt_page_table.sv =====
// Page table: frame memory, per-page valid bits and the free frame allocator.
`timescale 1ns / 1ps

module tlbpt_page_table #(
   parameter int PAGE_COUNT = tlbpt_pkg::DEF_PAGE_COUNT,
   parameter int PAGE_W     = $clog2(PAGE_COUNT)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tlbpt_pkg::tlbpt_pt_ctrl_type    ctrl,
   input  logic [PAGE_W-1:0]               page,
   output logic [tlbpt_pkg::FRAME_W-1:0]   rd_frame,
   output logic                            page_valid,
   output logic [tlbpt_pkg::FRAME_W-1:0]   next_frame
);
   import tlbpt_pkg::*;

   logic [FRAME_W-1:0]    frame_mem [PAGE_COUNT];
   logic [FRAME_W-1:0]    rd_frame_ff;
   logic [PAGE_COUNT-1:0] page_valid_ff;
   logic [FREE_CNT_W-1:0] free_cnt_ff;
   logic [FREE_CNT_W-1:0] free_cnt_in;

   // frame memory, registered read
   always_ff @(posedge clock) begin
      if (ctrl.alloc_en) begin
         frame_mem[page] <= next_frame;
      end
      if (ctrl.rd_en) begin
         rd_frame_ff <= frame_mem[page];
      end
   end

   // valid bits, cleared at once by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         page_valid_ff <= '0;
      end else if (ctrl.alloc_en) begin
         page_valid_ff[page] <= 1'b1;
      end
   end

   // saturating free frame counter
   always_comb begin
      free_cnt_in = free_cnt_ff;
      if (ctrl.alloc_en && (free_cnt_ff < FRAME_LIMIT)) begin
         free_cnt_in = free_cnt_ff + FREE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_cnt_ff <= '0;
      end else begin
         free_cnt_ff <= free_cnt_in;
      end
   end

   assign rd_frame   = rd_frame_ff;
   assign page_valid = page_valid_ff[page];
   assign next_frame = free_cnt_ff[FRAME_W-1:0];

endmodule

// ===== sv/tlb_page_table_translator.sv =====
// Top level: address translator with a chain of TLB cells and a demand-paged page table.
//
//   channel  ports                                  handshake
//   request  req_virtual_address                    start, busy (accept: start & !busy)
//   result   rsp_phys_addr, rsp_frame_number,       rsp_strobe, one cycle, no back-pressure
//            rsp_tlb_hit, rsp_page_fault
//
// A word passes through a lookup cycle, in which the TLB chain is searched
// and the page table memory is read through its registered port, and a resolve
// cycle that picks the frame, allocates on a fault and refills the TLB. busy is
// high only in the lookup cycle, so a new word may start in the resolve cycle of the last.
// The result appears on the cycle after resolve. Synchronous reset clears the
// TLB and page valid bits and the counters; there is no clearing pass.
`timescale 1ns / 1ps

module tlb_page_table_translator #(
   parameter int TLB_ENTRIES = tlbpt_pkg::DEF_TLB_ENTRIES,
   parameter int PAGE_COUNT  = tlbpt_pkg::DEF_PAGE_COUNT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [tlbpt_pkg::VA_W-1:0]         req_virtual_address,
   output logic                               rsp_strobe,
   output logic [tlbpt_pkg::VA_W-1:0]         rsp_phys_addr,
   output logic [tlbpt_pkg::FRAME_W-1:0]      rsp_frame_number,
   output logic                               rsp_tlb_hit,
   output logic                               rsp_page_fault
);
   import tlbpt_pkg::*;

   localparam int TLB_IDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
   localparam int PAGE_W    = $clog2(PAGE_COUNT);
   localparam int RED_W     = PAGE_TAG_W + 4;

   tlbpt_state_type        state_ff;
   tlbpt_state_type        state_in;
   logic                   accept;
   logic [PAGE_TAG_W-1:0]  page_red;
   logic [RED_W-1:0]       red_rem;
   logic [PAGE_TAG_W-1:0]  page_ff;
   logic [OFFSET_W-1:0]    offset_ff;
   tlbpt_match_type        match_chain [TLB_ENTRIES+1];
   tlbpt_match_type        match_ff;
   logic [TLB_IDX_W-1:0]   tlb_ptr_ff;
   logic [TLB_IDX_W-1:0]   tlb_ptr_in;
   tlbpt_pt_ctrl_type      pt_ctrl;
   logic [FRAME_W-1:0]     pt_rd_frame;
   logic                   pt_page_valid;
   logic [FRAME_W-1:0]     pt_next_frame;
   logic                   fin;
   logic                   miss;
   logic                   fault;
   logic [FRAME_W-1:0]     frame_sel;
   logic                   rsp_strobe_ff;
   logic [VA_W-1:0]        rsp_pa_ff;
   logic [FRAME_W-1:0]     rsp_frame_ff;
   logic                   rsp_hit_ff;
   logic                   rsp_fault_ff;

   // page number reduced modulo PAGE_COUNT by restoring subtraction
   always_comb begin
      red_rem = RED_W'(req_virtual_address[VA_W-1:OFFSET_W]);
      for (int k = 3; k >= 0; k--) begin
         if (red_rem >= RED_W'(PAGE_COUNT << k)) begin
            red_rem = red_rem - RED_W'(PAGE_COUNT << k);
         end
      end
      page_red = red_rem[PAGE_TAG_W-1:0];
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (start) state_in = ST_LOOK;
         ST_LOOK: state_in = ST_FIN;
         ST_FIN:  state_in = start ? ST_LOOK : ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      busy           = (state_ff == ST_LOOK);
      fin            = (state_ff == ST_FIN);
      pt_ctrl.rd_en  = (state_ff == ST_LOOK);
      pt_ctrl.alloc_en = fault;
   end

   assign accept = start && !busy;

   // request word capture
   always_ff @(posedge clock) begin
      if (accept) begin
         page_ff   <= page_red;
         offset_ff <= req_virtual_address[OFFSET_W-1:0];
      end
   end

   // TLB cell chain; lowest index wins
   assign match_chain[0] = '0;

   for (genvar i = 0; i < TLB_ENTRIES; i++) begin : g_cell
      tlbpt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .wr_en     (fin && miss && (tlb_ptr_ff == TLB_IDX_W'(i))),
         .wr_tag    (page_ff),
         .wr_frame  (frame_sel),
         .look_page (page_ff),
         .chain_in  (match_chain[i]),
         .chain_out (match_chain[i+1])
      );
   end

   // lookup result held for the resolve cycle
   always_ff @(posedge clock) begin
      if (state_ff == ST_LOOK) begin
         match_ff <= match_chain[TLB_ENTRIES];
      end
   end

   tlbpt_page_table #(
      .PAGE_COUNT (PAGE_COUNT),
      .PAGE_W     (PAGE_W)
   ) u_page_table (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (pt_ctrl),
      .page       (page_ff[PAGE_W-1:0]),
      .rd_frame   (pt_rd_frame),
      .page_valid (pt_page_valid),
      .next_frame (pt_next_frame)
   );

   // resolve: TLB frame, page table frame, or a freshly allocated one
   always_comb begin
      miss  = !match_ff.hit;
      fault = fin && miss && !pt_page_valid;
      if (!miss) begin
         frame_sel = match_ff.frame;
      end else if (pt_page_valid) begin
         frame_sel = pt_rd_frame;
      end else begin
         frame_sel = pt_next_frame;
      end
   end

   // FIFO refill pointer, wraps at TLB_ENTRIES
   always_comb begin
      tlb_ptr_in = tlb_ptr_ff;
      if (fin && miss) begin
         if (tlb_ptr_ff == TLB_IDX_W'(TLB_ENTRIES - 1)) begin
            tlb_ptr_in = '0;
         end else begin
            tlb_ptr_in = tlb_ptr_ff + TLB_IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tlb_ptr_ff <= '0;
      end else begin
         tlb_ptr_ff <= tlb_ptr_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= fin;
      end
   end

   always_ff @(posedge clock) begin
      if (fin) begin
         rsp_pa_ff    <= {frame_sel, offset_ff};
         rsp_frame_ff <= frame_sel;
         rsp_hit_ff   <= !miss;
         rsp_fault_ff <= fault;
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_phys_addr    = rsp_pa_ff;
   assign rsp_frame_number = rsp_frame_ff;
   assign rsp_tlb_hit      = rsp_hit_ff;
   assign rsp_page_fault   = rsp_fault_ff;

endmodule

// ===== tb/sv/tb_tlbpt_scoreboard_pkg.sv =====
// Scoreboard class holding a software TLB and page table that predicts each translation.
`timescale 1ns / 1ps

package tb_tlbpt_scoreboard_pkg;
   import tlbpt_pkg::*;

   // one translated word as seen on the result ports
   typedef struct {
      logic [VA_W-1:0]    phys_addr;
      logic [FRAME_W-1:0] frame;
      logic               tlb_hit;
      logic               page_fault;
   } xlat_word_type;

   class xlat_scoreboard;
      // shadow TLB
      logic [PAGE_TAG_W-1:0] tlb_tag   [DEF_TLB_ENTRIES];
      logic [FRAME_W-1:0]    tlb_frame [DEF_TLB_ENTRIES];
      bit                    tlb_valid [DEF_TLB_ENTRIES];
      int unsigned           fifo_slot;
      // shadow page table
      logic [FRAME_W-1:0]    page_frame [DEF_PAGE_COUNT];
      bit                    page_valid [DEF_PAGE_COUNT];
      logic [FREE_CNT_W-1:0] next_free;
      // translations accepted but not yet returned
      xlat_word_type         pending_xlat[$];
      int unsigned           mismatch_count;

      function new();
         foreach (tlb_valid[i]) begin
            tlb_valid[i] = 1'b0;
            tlb_tag[i]   = '0;
            tlb_frame[i] = '0;
         end
         foreach (page_valid[i]) begin
            page_valid[i] = 1'b0;
            page_frame[i] = '0;
         end
         fifo_slot      = 0;
         next_free      = '0;
         mismatch_count = 0;
      endfunction

      // one lookup: TLB first, then page table, allocating on a fault
      function xlat_word_type translate_address(logic [VA_W-1:0] va);
         xlat_word_type         w;
         logic [PAGE_TAG_W-1:0] page;
         page         = PAGE_TAG_W'((va >> OFFSET_W) % DEF_PAGE_COUNT);
         w.frame      = '0;
         w.tlb_hit    = 1'b0;
         w.page_fault = 1'b0;
         // lowest matching entry wins
         for (int i = 0; i < DEF_TLB_ENTRIES; i++) begin
            if (tlb_valid[i] && tlb_tag[i] == page) begin
               w.frame   = tlb_frame[i];
               w.tlb_hit = 1'b1;
               break;
            end
         end
         if (!w.tlb_hit) begin
            if (!page_valid[page]) begin
               w.frame          = next_free[FRAME_W-1:0];
               page_frame[page] = w.frame;
               page_valid[page] = 1'b1;
               if (next_free < FRAME_LIMIT)
                  next_free = next_free + 1'b1;
               w.page_fault = 1'b1;
            end else begin
               w.frame = page_frame[page];
            end
            // refill at the FIFO slot
            tlb_tag[fifo_slot]   = page;
            tlb_frame[fifo_slot] = w.frame;
            tlb_valid[fifo_slot] = 1'b1;
            fifo_slot            = (fifo_slot + 1) % DEF_TLB_ENTRIES;
         end
         w.phys_addr = {w.frame, va[OFFSET_W-1:0]};
         return w;
      endfunction

      function void note_address(logic [VA_W-1:0] va);
         pending_xlat.push_back(translate_address(va));
      endfunction

      function int unsigned outstanding();
         return pending_xlat.size();
      endfunction

      function void compare_field(string name, logic [VA_W-1:0] exp_val,
                                  logic [VA_W-1:0] act_val);
         if (act_val !== exp_val) begin
            mismatch_count++;
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, exp_val, act_val);
         end
      endfunction

      function void check_word(logic [VA_W-1:0] pa, logic [FRAME_W-1:0] fn,
                               logic hit, logic fault);
         xlat_word_type w;
         if (pending_xlat.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected word, expected none actual pa 0x%0h frame 0x%0h",
                     $time, pa, fn);
            return;
         end
         w = pending_xlat.pop_front();
         compare_field("phys_addr", w.phys_addr, pa);
         compare_field("frame_number", VA_W'(w.frame), VA_W'(fn));
         compare_field("tlb_hit", VA_W'(w.tlb_hit), VA_W'(hit));
         compare_field("page_fault", VA_W'(w.page_fault), VA_W'(fault));
      endfunction
   endclass

endpackage

// ===== tb/sv/tb_tlb_page_table_translator.sv =====
// Testbench top: drives address words into the translator and checks every result word.
`timescale 1ns / 1ps

module tb_tlb_page_table_translator;
   import tlbpt_pkg::*;
   import tb_tlbpt_scoreboard_pkg::*;

   localparam int RANDOM_WORDS = 950;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [VA_W-1:0]     req_virtual_address;
   logic                rsp_strobe;
   logic [VA_W-1:0]     rsp_phys_addr;
   logic [FRAME_W-1:0]  rsp_frame_number;
   logic                rsp_tlb_hit;
   logic                rsp_page_fault;

   xlat_scoreboard      xlat_sb;
   int unsigned         cycle_count;
   logic [7:0]          recent_pages[$];
   int unsigned         burst_left;

   tlb_page_table_translator i_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_virtual_address  (req_virtual_address),
      .rsp_strobe           (rsp_strobe),
      .rsp_phys_addr        (rsp_phys_addr),
      .rsp_frame_number     (rsp_frame_number),
      .rsp_tlb_hit          (rsp_tlb_hit),
      .rsp_page_fault       (rsp_page_fault)
   );

   // 8 ns clock
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // result monitor: a word is taken on every strobe
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         xlat_sb.check_word(rsp_phys_addr, rsp_frame_number,
                            rsp_tlb_hit, rsp_page_fault);
   end

   // present one word and hold it until accepted
   task automatic send_word(logic [VA_W-1:0] va);
      req_virtual_address <= va;
      start               <= 1'b1;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      xlat_sb.note_address(va);
      recent_pages.push_back(va[15:8]);
      if (recent_pages.size() > 12)
         void'(recent_pages.pop_front());
   endtask

   // end of a burst: drop start for a random gap, sometimes none
   task automatic pace_sender();
      int unsigned gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 7);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // recent pages (TLB hits), some low pages (page table reads), rest anywhere
   function automatic logic [VA_W-1:0] pick_address();
      logic [7:0]  page;
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 40 && recent_pages.size() > 0)
         page = recent_pages[$urandom_range(0, recent_pages.size() - 1)];
      else if (sel < 60)
         page = 8'($urandom_range(0, 47));
      else
         page = 8'($urandom_range(0, 255));
      return {page, 8'($urandom_range(0, 255))};
   endfunction

   initial begin
      xlat_sb             = new();
      cycle_count         = 0;
      burst_left          = 0;
      reset               = 1'b1;
      start               = 1'b0;
      req_virtual_address = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, hit after fault, TLB wrap and eviction
      send_word(16'h0000);     // first fault, frame 0
      send_word(16'h00FF);     // TLB hit on same page
      send_word(16'hFFFF);     // top page faults
      send_word(16'hFF00);     // hit
      for (int p = 1; p <= 15; p++)
         send_word({8'(p), 8'(p * 17)});  // fills TLB, page 0x0F evicts slot 0
      send_word(16'h00AA);     // evicted page: page table hit, no fault
      send_word(16'hFF55);     // same again for the top page
      send_word(16'h0F5A);     // still in TLB
      send_word(16'h8080);     // fresh fault mid range
      start <= 1'b0;
      repeat (3) @(posedge clock);

      // random traffic in bursts
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         send_word(pick_address());
         pace_sender();
      end
      start <= 1'b0;

      // drain
      while (xlat_sb.outstanding() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (xlat_sb.mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
